/* design/fdm_pkg.sv */
// Shared constants, widths and the store access struct of the stereo
// fractional delay mix core. Depends on nothing; every design file uses it.
`default_nettype none

package fdm_pkg;

   // Store geometry and sample format
   localparam int SAMPLE_BITS = 24;
   localparam int TOP_INDEX   = 16384;
   localparam int MAX_DELAY   = 16380;
   localparam int STORE_DEPTH = TOP_INDEX + 1;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   // Configuration register widths
   localparam int DELAY_BITS = 14;
   localparam int FRAC_BITS  = 17;
   localparam int PHASE_BITS = 17;

   // Fixed point scales
   localparam int Q16_ONE    = 65536;
   localparam int Q15_ONE    = 32768;
   localparam int FRAC_SHIFT = 16;
   localparam int MIX_SHIFT  = 15;
   localparam int GAIN_BITS  = 16;

   // Shared multiplier operand and product widths
   localparam int OPA_BITS  = SAMPLE_BITS + 1;
   localparam int OPB_BITS  = 18;
   localparam int PROD_BITS = OPA_BITS + OPB_BITS;
   localparam int ACC_BITS  = PROD_BITS + 1;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DELAY    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRACTION = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE    = 2'd2;

   // One write and two reads of a channel store in the same cycle
   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [ADDR_BITS-1:0] rd_addr_a;
      logic [ADDR_BITS-1:0] rd_addr_b;
   } store_req_type;

endpackage

`default_nettype wire

/* design/fdm_store.sv */
// Circular sample store of one channel: one write port, two registered reads.
// Depends on fdm_pkg for depth, widths and the access struct.
`default_nettype none

module fdm_store (
   input  wire                                    clock,
   input  wire  fdm_pkg::store_req_type           req,
   input  wire  signed [fdm_pkg::SAMPLE_BITS-1:0] wr_data,
   output logic signed [fdm_pkg::SAMPLE_BITS-1:0] rd_a,
   output logic signed [fdm_pkg::SAMPLE_BITS-1:0] rd_b
);

   logic signed [fdm_pkg::SAMPLE_BITS-1:0] mem [fdm_pkg::STORE_DEPTH];
   logic signed [fdm_pkg::SAMPLE_BITS-1:0] rd_a_ff;
   logic signed [fdm_pkg::SAMPLE_BITS-1:0] rd_b_ff;

   // Write the new word; reads return the old contents on an address clash
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= wr_data;
      end
      if (req.rd_en) begin
         rd_a_ff <= mem[req.rd_addr_a];
         rd_b_ff <= mem[req.rd_addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

`default_nettype wire

/* design/fdm_mul.sv */
// Shared signed multiplier with a registered product, reused for every
// product of an item. Depends on fdm_pkg for operand widths.
`default_nettype none

module fdm_mul (
   input  wire                                  clock,
   input  wire                                  en,
   input  wire  signed [fdm_pkg::OPA_BITS-1:0]  op_a,
   input  wire  signed [fdm_pkg::OPB_BITS-1:0]  op_b,
   output logic signed [fdm_pkg::PROD_BITS-1:0] prod
);

   logic signed [fdm_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [fdm_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = fdm_pkg::PROD_BITS'(op_a) * fdm_pkg::PROD_BITS'(op_b);

   // Hold the product while disabled
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* design/stereo_fractional_delay_mix_core.sv */
// Top level of the stereo fractional delay mix: sequencer, configuration
// registers and datapath. Depends on fdm_pkg, fdm_store and fdm_mul.
//
// Usage:
//   req_ channel: one stereo word per item, left in the low half.
//   rsp_ channel: one delayed and mixed stereo word per item, same packing.
//   csr_ channel: register writes (0 delay, 1 fraction, 2 mix phase); always
//     ready, write only while no item is in flight.
// Sequence: the accept step writes both stores and issues both reads, then
//   the item makes six passes through the one shared multiplier and a final
//   add-and-saturate step that loads the result word into the output
//   register. req_tready is high only while idle.
// The result sits in an output register, so the next word is accepted while
//   it waits; if the receiver still stalls when the next result is done, the
//   sequencer holds in its last step until rsp_tready.
// Reset (synchronous): write pointer and fill count go to zero, registers to
//   their defaults, the output empties. Store entries not yet written since
//   reset read as zero through the fill count, so no clearing pass is run.
`default_nettype none

module stereo_fractional_delay_mix_core (
   input  wire                                   clock,
   input  wire                                   reset,
   // slave side: [23:0] left_in, [47:24] right_in
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [2*fdm_pkg::SAMPLE_BITS-1:0]     req_tdata,
   // master side: [23:0] left_out, [47:24] right_out
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [2*fdm_pkg::SAMPLE_BITS-1:0]     rsp_tdata,
   // configuration write channel
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [fdm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [fdm_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int SB  = fdm_pkg::SAMPLE_BITS;
   localparam int AB  = fdm_pkg::ADDR_BITS;
   localparam int ACB = fdm_pkg::ACC_BITS;

   localparam logic [AB-1:0] TOP_ADDR = AB'(fdm_pkg::TOP_INDEX);
   localparam logic [AB:0]   DEPTH_W  = (AB+1)'(fdm_pkg::STORE_DEPTH);
   localparam logic signed [fdm_pkg::PROD_BITS-1:0] ROUND_WET =
      fdm_pkg::PROD_BITS'(1 << (fdm_pkg::FRAC_SHIFT - 1));
   localparam logic signed [ACB-1:0] ROUND_MIX = ACB'(1 << (fdm_pkg::MIX_SHIFT - 1));
   localparam logic signed [ACB-1:0] SAT_HI    = ACB'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [ACB-1:0] SAT_LO    = -SAT_HI - ACB'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF_L,
      ST_DIFF_R,
      ST_DRY_L,
      ST_WET_L,
      ST_DRY_R,
      ST_WET_R,
      ST_FINISH
   } state_type;

   function automatic logic signed [SB-1:0] sat_sample(input logic signed [ACB-1:0] v);
      logic signed [ACB-1:0] scaled;
      scaled = v >>> fdm_pkg::MIX_SHIFT;
      if (scaled > SAT_HI) begin
         return SB'(SAT_HI);
      end else if (scaled < SAT_LO) begin
         return SB'(SAT_LO);
      end else begin
         return scaled[SB-1:0];
      end
   endfunction

   // Control state
   state_type                        state_ff, state_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [AB-1:0]                    wp_ff, wp_in;
   logic [AB-1:0]                    fill_ff, fill_in;
   logic [fdm_pkg::DELAY_BITS-1:0]   delay_ff;
   logic [fdm_pkg::FRAC_BITS-1:0]    fraction_ff;
   logic signed [fdm_pkg::PHASE_BITS-1:0] phase_ff;

   // Per-item payload
   logic signed [SB-1:0]             xl_ff, xr_ff;
   logic [fdm_pkg::FRAC_BITS-1:0]    f_ff;
   logic signed [fdm_pkg::OPB_BITS-1:0] g_ff;
   logic [fdm_pkg::GAIN_BITS-1:0]    d_ff;
   logic                             a_new_ff, a_valid_ff, b_valid_ff;
   logic signed [SB-1:0]             wetl_ff, wetr_ff;
   logic signed [ACB-1:0]            acc_ff;
   logic signed [SB-1:0]             outl_ff;
   logic signed [SB-1:0]             rsp_l_ff, rsp_r_ff;

   logic                             req_fire;
   logic [fdm_pkg::DELAY_BITS-1:0]   offset;
   logic [AB:0]                      base;
   logic [AB-1:0]                    addr_a, addr_b;
   logic [fdm_pkg::FRAC_BITS-1:0]    f_clamp;
   logic signed [fdm_pkg::OPB_BITS-1:0] p_ext, abs_p, g_val;
   logic [fdm_pkg::GAIN_BITS-1:0]    d_val;
   fdm_pkg::store_req_type           store_req;
   logic signed [SB-1:0]             rd_la, rd_lb, rd_ra, rd_rb;
   logic signed [SB-1:0]             al, bl, ar, br;
   logic signed [fdm_pkg::OPA_BITS-1:0] diff_l, diff_r;
   logic                             mul_en;
   logic signed [fdm_pkg::OPA_BITS-1:0] op_a;
   logic signed [fdm_pkg::OPB_BITS-1:0] op_b;
   logic signed [fdm_pkg::PROD_BITS-1:0] prod, prod_rnd;
   logic signed [fdm_pkg::PROD_BITS-1:0] wet_frac;
   logic signed [ACB-1:0]            prod_ext, mix_sum;
   logic                             finish_go;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_r_ff, rsp_l_ff};

   // Clamp the delay, then find both read addresses with one wrap step
   always_comb begin
      offset = (delay_ff > fdm_pkg::DELAY_BITS'(fdm_pkg::MAX_DELAY))
             ? fdm_pkg::DELAY_BITS'(fdm_pkg::MAX_DELAY) : delay_ff;
      base   = {1'b0, wp_ff} + (AB+1)'(offset);
      addr_a = (base >= DEPTH_W) ? AB'(base - DEPTH_W) : base[AB-1:0];
      addr_b = (addr_a == TOP_ADDR) ? '0 : addr_a + AB'(1);
   end

   // Derive blend weight, wet gain and dry gain from the registers
   always_comb begin
      f_clamp = (fraction_ff > fdm_pkg::FRAC_BITS'(fdm_pkg::Q16_ONE))
              ? fdm_pkg::FRAC_BITS'(fdm_pkg::Q16_ONE) : fraction_ff;
      p_ext   = fdm_pkg::OPB_BITS'(phase_ff);
      abs_p   = (p_ext < 0) ? -p_ext : p_ext;
      g_val   = (p_ext < fdm_pkg::OPB_BITS'(fdm_pkg::Q15_ONE))
              ? p_ext : fdm_pkg::OPB_BITS'(fdm_pkg::Q15_ONE);
      d_val   = (abs_p < fdm_pkg::OPB_BITS'(fdm_pkg::Q15_ONE))
              ? fdm_pkg::GAIN_BITS'(fdm_pkg::OPB_BITS'(fdm_pkg::Q15_ONE) - abs_p) : '0;
   end

   assign store_req.wr_en     = req_fire;
   assign store_req.rd_en     = req_fire;
   assign store_req.wr_addr   = wp_ff;
   assign store_req.rd_addr_a = addr_a;
   assign store_req.rd_addr_b = addr_b;

   fdm_store u_store_l (
      .clock   (clock),
      .req     (store_req),
      .wr_data (req_tdata[SB-1:0]),
      .rd_a    (rd_la),
      .rd_b    (rd_lb)
   );

   fdm_store u_store_r (
      .clock   (clock),
      .req     (store_req),
      .wr_data (req_tdata[2*SB-1:SB]),
      .rd_a    (rd_ra),
      .rd_b    (rd_rb)
   );

   // Pick the taps: the word written this item, a stored word, or zero if unwritten
   always_comb begin
      al = a_new_ff ? xl_ff : (a_valid_ff ? rd_la : '0);
      ar = a_new_ff ? xr_ff : (a_valid_ff ? rd_ra : '0);
      bl = b_valid_ff ? rd_lb : '0;
      br = b_valid_ff ? rd_rb : '0;
      diff_l = fdm_pkg::OPA_BITS'(bl) - fdm_pkg::OPA_BITS'(al);
      diff_r = fdm_pkg::OPA_BITS'(br) - fdm_pkg::OPA_BITS'(ar);
   end

   // Steer the shared multiplier by step
   always_comb begin
      mul_en = 1'b1;
      op_a   = '0;
      op_b   = '0;
      case (state_ff)
         ST_DIFF_L: begin
            op_a = diff_l;
            op_b = fdm_pkg::OPB_BITS'(f_ff);
         end
         ST_DIFF_R: begin
            op_a = diff_r;
            op_b = fdm_pkg::OPB_BITS'(f_ff);
         end
         ST_DRY_L: begin
            op_a = fdm_pkg::OPA_BITS'(xl_ff);
            op_b = fdm_pkg::OPB_BITS'(d_ff);
         end
         ST_WET_L: begin
            op_a = fdm_pkg::OPA_BITS'(wetl_ff);
            op_b = g_ff;
         end
         ST_DRY_R: begin
            op_a = fdm_pkg::OPA_BITS'(xr_ff);
            op_b = fdm_pkg::OPB_BITS'(d_ff);
         end
         ST_WET_R: begin
            op_a = fdm_pkg::OPA_BITS'(wetr_ff);
            op_b = g_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   fdm_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Rounded blend term and the wet plus dry sum
   always_comb begin
      prod_rnd = prod + ROUND_WET;
      wet_frac = prod_rnd >>> fdm_pkg::FRAC_SHIFT;
      prod_ext = ACB'(prod);
      mix_sum  = acc_ff + prod_ext;
   end

   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // Next state, pointer and fill count
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DIFF_L;
               wp_in    = (wp_ff == '0) ? TOP_ADDR : wp_ff - AB'(1);
               fill_in  = (fill_ff == TOP_ADDR) ? fill_ff : fill_ff + AB'(1);
            end
         end
         ST_DIFF_L: state_in = ST_DIFF_R;
         ST_DIFF_R: state_in = ST_DRY_L;
         ST_DRY_L:  state_in = ST_WET_L;
         ST_WET_L:  state_in = ST_DRY_R;
         ST_DRY_R:  state_in = ST_WET_R;
         ST_WET_R:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (finish_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state, pointer, fill count, registers and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         delay_ff     <= '0;
         fraction_ff  <= '0;
         phase_ff     <= fdm_pkg::PHASE_BITS'(fdm_pkg::Q15_ONE);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fdm_pkg::REG_DELAY:    delay_ff    <= csr_wdata[fdm_pkg::DELAY_BITS-1:0];
               fdm_pkg::REG_FRACTION: fraction_ff <= csr_wdata[fdm_pkg::FRAC_BITS-1:0];
               fdm_pkg::REG_PHASE:    phase_ff    <= csr_wdata[fdm_pkg::PHASE_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Capture the item, then advance the datapath one step per cycle; the last step holds while an untaken result waits
   always_ff @(posedge clock) begin
      if (req_fire) begin
         xl_ff      <= req_tdata[SB-1:0];
         xr_ff      <= req_tdata[2*SB-1:SB];
         f_ff       <= f_clamp;
         g_ff       <= g_val;
         d_ff       <= d_val;
         a_new_ff   <= (offset == '0);
         a_valid_ff <= (AB'(offset) <= fill_ff);
         b_valid_ff <= (AB'(offset) < fill_ff);
      end
      case (state_ff)
         ST_DIFF_R: wetl_ff <= al + wet_frac[SB-1:0];
         ST_DRY_L:  wetr_ff <= ar + wet_frac[SB-1:0];
         ST_WET_L:  acc_ff  <= prod_ext + ROUND_MIX;
         ST_DRY_R:  outl_ff <= sat_sample(mix_sum);
         ST_WET_R:  acc_ff  <= prod_ext + ROUND_MIX;
         default: ;
      endcase
      if (finish_go) begin
         rsp_l_ff <= outl_ff;
         rsp_r_ff <= sat_sample(mix_sum);
      end
   end

   // The fill count saturates at the top index
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= TOP_ADDR)
      else $error("fill count beyond store top");

   // Both read addresses stay inside the store
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (addr_a <= TOP_ADDR) && (addr_b <= TOP_ADDR))
      else $error("read address outside store");

   // Each accepted word moves the write pointer down by one, wrapping at zero
   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> wp_ff == (($past(wp_ff) == '0) ? TOP_ADDR : $past(wp_ff) - AB'(1)))
      else $error("write pointer did not step");

   // A finished result never overwrites one the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_tdata))
      else $error("pending result overwritten");

endmodule

`default_nettype wire
